// ===== design/smm_pkg.sv =====
`timescale 1ns / 1ps

package smm_pkg;

    localparam int MAT_N      = 16;
    localparam int SIZE_LIMIT = (MAT_N < 16) ? MAT_N : 16;
    localparam int ADDR_W     = (SIZE_LIMIT > 1) ? $clog2(SIZE_LIMIT) : 1;
    localparam int CNT_W      = $clog2(2 * SIZE_LIMIT + 2);

    localparam int SIZE_W = 5;
    localparam int IDX_W  = 4;
    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 38;

    localparam logic CMD_WRITE_B = 1'b0;
    localparam logic CMD_A_ROW   = 1'b1;

    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic [ADDR_W-1:0]        k;
        logic signed [ELEM_W-1:0] a;
    } t_tok;

endpackage

// ===== design/smm_in_if.sv =====
`timescale 1ns / 1ps

interface smm_in_if import smm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element;

    modport source (output valid, output cmd, output row_index, output col_index,
                    output element, input ready);
    modport sink   (input valid, input cmd, input row_index, input col_index,
                    input element, output ready);
endinterface

// ===== design/smm_out_if.sv =====
`timescale 1ns / 1ps

interface smm_out_if import smm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [ACC_W-1:0] product;
    logic                    last;

    modport source (output valid, output out_row, output out_col, output product,
                    output last, input ready);
    modport sink   (input valid, input out_row, input out_col, input product,
                    input last, output ready);
endinterface

// ===== design/smm_ram.sv =====
`timescale 1ns / 1ps

module smm_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/smm_cell.sv =====
`timescale 1ns / 1ps

module smm_cell import smm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_tok                     i_tok,
    output t_tok                     o_tok,
    input  logic                     i_we,
    input  logic [ADDR_W-1:0]        i_waddr,
    input  logic signed [ELEM_W-1:0] i_wdata,
    output logic signed [ACC_W-1:0]  o_acc
);

    t_tok                     r_tok;
    logic                     r_v2;
    logic                     r_first2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [ELEM_W-1:0]        w_bdata;

    smm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (SIZE_LIMIT)
    ) u_bcol (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_tok.k),
        .o_rdata (w_bdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            r_tok    <= i_tok;
            r_v2     <= r_tok.valid;
            r_first2 <= r_tok.first;
            r_prod   <= $signed(r_tok.a) * $signed(w_bdata);
            if (r_v2) begin
                if (r_first2) begin
                    r_acc <= ACC_W'(r_prod);
                end else begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
        end
    end

    assign o_tok = r_tok;
    assign o_acc = r_acc;

endmodule

// ===== design/square_matrix_multiply.sv =====
// After the transaction that carries the last A column of a row, the row is computed in
// the cell chain, then products follow one per cycle while o_out is ready.
// Throughput: B and A element transactions are taken one per cycle; a row end holds
// input ready low until the last product of the row has been emitted.
// Reset: synchronous, active low; clears control state and sets size_in_use to 16.
// The B and A stores are undefined until written.
`timescale 1ns / 1ps

module square_matrix_multiply import smm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    smm_in_if.sink            i_in,
    smm_out_if.source         o_out
);

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_EMIT} t_state;

    t_state                   r_state;
    logic [SIZE_W-1:0]        r_size;
    logic [CNT_W-1:0]         r_cnt;
    logic [ADDR_W-1:0]        r_ocol;
    logic [IDX_W-1:0]         r_row;
    t_tok                     r_tok;
    logic signed [ELEM_W-1:0] r_a_store [SIZE_LIMIT];

    logic                     r_ov;
    logic [IDX_W-1:0]         r_out_row;
    logic [IDX_W-1:0]         r_out_col;
    logic signed [ACC_W-1:0]  r_out_product;
    logic                     r_out_last;

    logic [SIZE_W-1:0]        w_n;
    logic                     w_in_range;
    logic                     w_acc;
    logic                     w_a_we;
    logic                     w_b_we;
    logic                     w_start;
    logic                     w_ocol_last;
    logic                     w_emit;
    t_tok                     w_chain [SIZE_LIMIT+1];
    logic signed [ACC_W-1:0]  w_acc_arr [SIZE_LIMIT];

    always_comb begin
        priority if (r_size == '0) begin
            w_n = SIZE_W'(1);
        end else if (r_size > SIZE_W'(SIZE_LIMIT)) begin
            w_n = SIZE_W'(SIZE_LIMIT);
        end else begin
            w_n = r_size;
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_in_range  = (SIZE_W'(i_in.row_index) < w_n) && (SIZE_W'(i_in.col_index) < w_n);
    assign w_a_we      = w_acc && w_in_range && (i_in.cmd == CMD_A_ROW);
    assign w_b_we      = w_acc && w_in_range && (i_in.cmd == CMD_WRITE_B);
    assign w_start     = w_a_we && (SIZE_W'(i_in.col_index) == w_n - SIZE_W'(1));
    assign w_ocol_last = (SIZE_W'(r_ocol) == w_n - SIZE_W'(1));
    assign w_emit      = (r_state == S_EMIT) && (!r_ov || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(16);
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            r_a_store[i_in.col_index[ADDR_W-1:0]] <= i_in.element;
        end
    end

    assign w_chain[0] = r_tok;

    for (genvar j = 0; j < SIZE_LIMIT; j++) begin : g_cell
        smm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_chain[j]),
            .o_tok   (w_chain[j+1]),
            .i_we    (w_b_we && (i_in.col_index == IDX_W'(j))),
            .i_waddr (i_in.row_index[ADDR_W-1:0]),
            .i_wdata (i_in.element),
            .o_acc   (w_acc_arr[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_ocol      <= '0;
            r_tok.valid <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_tok.valid <= 1'b0;
                    if (w_start) begin
                        r_state <= S_CALC;
                        r_cnt   <= '0;
                        r_row   <= i_in.row_index;
                    end
                end
                S_CALC: begin
                    r_tok.valid <= (r_cnt < CNT_W'(w_n));
                    r_tok.first <= (r_cnt == '0);
                    r_tok.k     <= r_cnt[ADDR_W-1:0];
                    r_tok.a     <= r_a_store[r_cnt[ADDR_W-1:0]];
                    r_cnt       <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'({w_n, 1'b1})) begin
                        r_state <= S_EMIT;
                        r_ocol  <= '0;
                    end
                end
                S_EMIT: begin
                    r_tok.valid <= 1'b0;
                    if (w_emit) begin
                        r_out_row     <= r_row;
                        r_out_col     <= IDX_W'(r_ocol);
                        r_out_product <= w_acc_arr[r_ocol];
                        r_out_last    <= w_ocol_last;
                        if (w_ocol_last) begin
                            r_state <= S_IDLE;
                            r_ocol  <= '0;
                        end else begin
                            r_ocol <= r_ocol + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign o_out.valid   = r_ov;
    assign o_out.out_row = r_out_row;
    assign o_out.out_col = r_out_col;
    assign o_out.product = r_out_product;
    assign o_out.last    = r_out_last;

`ifndef NO_ASSERTIONS
    a_tok_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok.valid |-> r_state == S_CALC)
        else $error("token issued outside compute phase");

    a_start_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> r_state == S_CALC)
        else $error("row end did not start compute phase");

    a_idle_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_ocol == '0)
        else $error("output column not rewound in idle");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

import smm_pkg::*;

typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ACC_W-1:0] product;
    logic                    last;
} t_product;

class product_scoreboard;
    logic [SIZE_W-1:0]        size_reg;
    logic signed [ELEM_W-1:0] b_mat [SIZE_LIMIT][SIZE_LIMIT];
    logic signed [ELEM_W-1:0] a_row [SIZE_LIMIT];
    t_product                 pending_products [$];
    int                       fail_count;

    function new();
        size_reg   = SIZE_W'(16);
        fail_count = 0;
    endfunction

    function int active_size();
        int n;
        n = int'(size_reg);
        if (n < 1) n = 1;
        if (n > SIZE_LIMIT) n = SIZE_LIMIT;
        return n;
    endfunction

    function void write_size(logic [SIZE_W-1:0] value);
        size_reg = value;
    endfunction

    function int pending();
        return pending_products.size();
    endfunction

    function void take_element(logic cmd, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                               logic signed [ELEM_W-1:0] elem);
        int       n;
        longint   sum;
        t_product p;
        n = active_size();
        if (row >= n || col >= n) return;
        if (cmd == CMD_WRITE_B) begin
            b_mat[row][col] = elem;
            return;
        end
        a_row[col] = elem;
        if (col != n - 1) return;
        for (int j = 0; j < n; j++) begin
            sum = 0;
            for (int k = 0; k < n; k++)
                sum += longint'(a_row[k]) * longint'(b_mat[k][j]);
            p.row     = row;
            p.col     = IDX_W'(j);
            p.product = ACC_W'(sum);
            p.last    = (j == n - 1);
            pending_products.push_back(p);
        end
    endfunction

    task report(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task check_product(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                       logic signed [ACC_W-1:0] product, logic last);
        t_product p;
        if (pending_products.size() == 0) begin
            report($sformatf("unexpected product row %0d col %0d value %0d", row, col, product));
            return;
        end
        p = pending_products.pop_front();
        if (row !== p.row)
            report($sformatf("out_row %0d, expected %0d", row, p.row));
        if (col !== p.col)
            report($sformatf("out_col %0d, expected %0d (row %0d)", col, p.col, p.row));
        if (product !== p.product)
            report($sformatf("product %0d, expected %0d (row %0d col %0d)",
                             product, p.product, p.row, p.col));
        if (last !== p.last)
            report($sformatf("last %0b, expected %0b (row %0d col %0d)",
                             last, p.last, p.row, p.col));
    endtask
endclass

module tb_top;

    localparam int SETTLE_CYCLES   = 5 * SIZE_LIMIT + 8;
    localparam int ITEMS_PER_PHASE = 12;
    localparam int NUM_PHASES      = 10;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_data;

    smm_in_if  u_in_if ();
    smm_out_if u_out_if ();

    square_matrix_multiply u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (u_in_if),
        .o_out      (u_out_if)
    );

    product_scoreboard sb = new();

    bit b_ok [SIZE_LIMIT][SIZE_LIMIT];
    bit a_ok [SIZE_LIMIT];
    int cur_n          = SIZE_LIMIT;
    int in_range_count = 0;
    bit src_idle       = 1'b1;
    bit sink_stalls    = 1'b1;

    int phase_sizes [NUM_PHASES] = '{1, 0, 3, 31, 2, 17, 5, 16, 4, 0};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int stall_left;
        stall_left = 0;
        u_out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (u_out_if.valid && u_out_if.ready)
                sb.check_product(u_out_if.out_row, u_out_if.out_col, u_out_if.product,
                                 u_out_if.last);
            if (stall_left == 0 && sink_stalls && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 3);
            if (stall_left > 0) begin
                u_out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                u_out_if.ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return ELEM_MIN;
            1: return ELEM_MAX;
            2: return '0;
            3: return '1;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic cmd, input int row, input int col,
                             input logic signed [ELEM_W-1:0] elem);
        u_in_if.valid     <= 1'b1;
        u_in_if.cmd       <= cmd;
        u_in_if.row_index <= IDX_W'(row);
        u_in_if.col_index <= IDX_W'(col);
        u_in_if.element   <= elem;
        @(posedge i_clk);
        while (!u_in_if.ready) @(posedge i_clk);
        sb.take_element(cmd, IDX_W'(row), IDX_W'(col), elem);
        if (row < cur_n && col < cur_n) begin
            in_range_count++;
            if (cmd == CMD_WRITE_B) b_ok[row][col] = 1'b1;
            else a_ok[col] = 1'b1;
        end
        if (src_idle && $urandom_range(0, 3) == 0) begin
            u_in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        u_in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_size(input int value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= SIZE_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_size(SIZE_W'(value));
        cur_n = (value < 1) ? 1 : (value > SIZE_LIMIT) ? SIZE_LIMIT : value;
    endtask

    task automatic fill_b();
        for (int k = 0; k < cur_n; k++)
            for (int j = 0; j < cur_n; j++)
                if (!b_ok[k][j]) send_item(CMD_WRITE_B, k, j, rand_elem());
    endtask

    // When stale is set, resend an earlier A entry only if it is unwritten or on a random draw.
    task automatic send_row(input int row, input bit stale);
        for (int k = 0; k < cur_n - 1; k++)
            if (!stale || !a_ok[k] || $urandom_range(0, 1) == 0)
                send_item(CMD_A_ROW, row, k, rand_elem());
        send_item(CMD_A_ROW, row, cur_n - 1, rand_elem());
    endtask

    task automatic run_random(input int goal);
        int   target;
        int   pick;
        int   row;
        int   col;
        logic cmd;
        bit   safe;
        target = in_range_count + goal;
        while (in_range_count < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                fill_b();
                send_row($urandom_range(0, cur_n - 1), $urandom_range(0, 2) == 0);
            end else if (pick < 8) begin
                send_item(CMD_WRITE_B, $urandom_range(0, cur_n - 1),
                          $urandom_range(0, cur_n - 1), rand_elem());
            end else begin
                cmd = 1'($urandom_range(0, 1));
                row = $urandom_range(0, SIZE_LIMIT - 1);
                col = $urandom_range(0, SIZE_LIMIT - 1);
                if (cmd == CMD_A_ROW && row < cur_n && col == cur_n - 1) begin
                    safe = 1'b1;
                    for (int k = 0; k < cur_n; k++) begin
                        if (k < cur_n - 1 && !a_ok[k]) safe = 1'b0;
                        for (int j = 0; j < cur_n; j++)
                            if (!b_ok[k][j]) safe = 1'b0;
                    end
                    if (!safe) cmd = CMD_WRITE_B;
                end
                send_item(cmd, row, col, rand_elem());
            end
        end
    endtask

    initial begin
        int size_value;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_data        <= '0;
        u_in_if.valid     <= 1'b0;
        u_in_if.cmd       <= CMD_WRITE_B;
        u_in_if.row_index <= '0;
        u_in_if.col_index <= '0;
        u_in_if.element   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full-size B with extreme first and last columns.
        for (int k = 0; k < SIZE_LIMIT; k++)
            for (int j = 0; j < SIZE_LIMIT; j++)
                send_item(CMD_WRITE_B, k, j, (j == 0) ? ELEM_MIN :
                          (j == SIZE_LIMIT - 1) ? ELEM_MAX : rand_elem());
        for (int k = 0; k < SIZE_LIMIT; k++)
            send_item(CMD_A_ROW, SIZE_LIMIT - 1, k, ELEM_MIN);
        send_item(CMD_A_ROW, 0, 3, ELEM_MAX);
        send_item(CMD_A_ROW, 0, SIZE_LIMIT - 1, ELEM_MAX);

        set_size(4);
        send_item(CMD_WRITE_B, 5, 0, ELEM_MAX);
        send_item(CMD_A_ROW, 1, 9, ELEM_MIN);
        send_item(CMD_A_ROW, SIZE_LIMIT - 1, 3, ELEM_MAX);
        send_row(2, 1'b0);

        set_size(0);
        send_item(CMD_A_ROW, 0, 1, ELEM_MAX);
        send_item(CMD_A_ROW, 0, 0, ELEM_MIN);

        set_size(31);
        send_item(CMD_A_ROW, 7, SIZE_LIMIT - 1, ELEM_MAX);

        for (int p = 0; p < NUM_PHASES; p++) begin
            size_value = (p == NUM_PHASES - 1) ? $urandom_range(0, 31) : phase_sizes[p];
            set_size(size_value);
            if (p == NUM_PHASES - 1) begin
                src_idle    = 1'b0;
                sink_stalls = 1'b0;
            end
            run_random(ITEMS_PER_PHASE);
        end

        drain();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d products never arrived", sb.pending()));
        if (sb.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
